/* hw/rtl/tcu_pkg.sv */
// shared types and constants of the threshold centroid unit
package tcu_pkg;

	localparam int GRAY_W  = 8;
	localparam int COORD_W = 10;
	localparam int THR_W   = 9;
	localparam int SUM_W   = 30;
	localparam int CNT_W   = 21;
	localparam int POS_LIM_W = 13;

	localparam logic [THR_W-1:0] THR_RESET = 9'd100;

	// frame limits, compared against the 10-bit coordinates
	localparam logic [POS_LIM_W-1:0] MAX_WIDTH  = 13'd1024;
	localparam logic [POS_LIM_W-1:0] MAX_HEIGHT = 13'd1024;

	localparam logic [SUM_W:0]   SUM_LIMIT   = 31'h3FFF_FFFF;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 21'h1F_FFFF;

	// quotient fits in COORD_W bits since every sum stays below 1024 * count
	localparam int DIV_STEPS = COORD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_WAIT
	} tcu_state_t;

	typedef struct packed {
		logic accept;    // pixel transfer this cycle
		logic close;     // the transferred pixel ends the frame
		logic div_step;  // advance both dividers by one quotient bit
		logic load_out;  // move the quotients into the output register
	} tcu_cmd_t;

endpackage

/* hw/rtl/tcu_div.sv */
// restoring divider, one quotient bit per step, for a quotient below 2**COORD_W
module tcu_div
	import tcu_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic [COORD_W-1:0] quotient
);

	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [COORD_W-1:0] bits_q;
	logic [CNT_W:0]     trial;
	logic               ge;

	assign trial = {rem_q, bits_q[COORD_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (load) begin
			// upper bits are already below the divisor
			rem_q  <= CNT_W'(dividend[SUM_W-1:COORD_W]);
			div_q  <= divisor;
			bits_q <= dividend[COORD_W-1:0];
		end else if (step) begin
			rem_q  <= ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			bits_q <= {bits_q[COORD_W-2:0], ge};
		end
	end

	assign quotient = bits_q;

endmodule

/* hw/rtl/tcu_datapath.sv */
// accumulators, threshold register, dividers and output register
module tcu_datapath
	import tcu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tcu_cmd_t           cmd,
	input  logic               cfg_wr_en,
	input  logic [THR_W-1:0]   cfg_wr_data,
	input  logic [GRAY_W-1:0]  gray,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               empty_frame
);

	logic [THR_W-1:0]   thr_q;
	logic [SUM_W-1:0]   sum_x_q;
	logic [SUM_W-1:0]   sum_y_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               empty_q;
	logic [COORD_W-1:0] center_x_q;
	logic [COORD_W-1:0] center_y_q;
	logic               empty_frame_q;

	logic               in_frame;
	logic               dark;
	logic               room;
	logic               hit;
	logic [SUM_W:0]     add_x;
	logic [SUM_W:0]     add_y;
	logic [SUM_W-1:0]   sum_x_nxt;
	logic [SUM_W-1:0]   sum_y_nxt;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [COORD_W-1:0] quot_x;
	logic [COORD_W-1:0] quot_y;

	always_comb begin
		in_frame = ({3'b000, pos_x} < MAX_WIDTH) && ({3'b000, pos_y} < MAX_HEIGHT);
		dark   = {1'b0, gray} < thr_q;
		add_x  = {1'b0, sum_x_q} + (SUM_W+1)'(pos_x);
		add_y  = {1'b0, sum_y_q} + (SUM_W+1)'(pos_y);
		// a pixel that would overflow any accumulator is dropped
		room   = (add_x <= SUM_LIMIT) && (add_y <= SUM_LIMIT) && (cnt_q < COUNT_LIMIT);
		hit    = in_frame && dark && room;
		sum_x_nxt = hit ? add_x[SUM_W-1:0] : sum_x_q;
		sum_y_nxt = hit ? add_y[SUM_W-1:0] : sum_y_q;
		cnt_nxt   = hit ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				if (cmd.close) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					cnt_q   <= '0;
				end else begin
					sum_x_q <= sum_x_nxt;
					sum_y_q <= sum_y_nxt;
					cnt_q   <= cnt_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close) begin
			empty_q <= (cnt_nxt == '0);
		end
		if (cmd.load_out) begin
			center_x_q    <= empty_q ? '0 : quot_x;
			center_y_q    <= empty_q ? '0 : quot_y;
			empty_frame_q <= empty_q;
		end
	end

	tcu_div u_div_x (
		.clk      (clk),
		.load     (cmd.close),
		.step     (cmd.div_step),
		.dividend (sum_x_nxt),
		.divisor  (cnt_nxt),
		.quotient (quot_x)
	);

	tcu_div u_div_y (
		.clk      (clk),
		.load     (cmd.close),
		.step     (cmd.div_step),
		.dividend (sum_y_nxt),
		.divisor  (cnt_nxt),
		.quotient (quot_y)
	);

	assign center_x    = center_x_q;
	assign center_y    = center_y_q;
	assign empty_frame = empty_frame_q;

endmodule

/* hw/rtl/tcu_ctrl.sv */
// controller: pixel transfers, divide sequencing and output handshake
module tcu_ctrl
	import tcu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     frame_end,
	output logic     out_valid,
	input  logic     out_ready,
	output tcu_cmd_t cmd
);

	tcu_state_t        state_q;
	tcu_state_t        state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.close) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.close    = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.close  = in_valid && frame_end;
				if (cmd.close) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// previous result must have left the output register
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_ACCUM;
				end
			end
			default: begin
				state_nxt = ST_ACCUM;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/threshold_centroid_unit.sv */
// top level of the threshold centroid unit
//
// Pixels arrive on the input channel (in_valid/in_ready) with gray, pos_x,
// pos_y and frame_end. A pixel with gray below the dark threshold and inside
// the frame adds its coordinates to the running sums. The transfer of a pixel
// with frame_end set closes the frame: its sums go to two restoring dividers
// and the accumulators clear. One result per frame appears on the output
// channel (out_valid/out_ready): the truncated mean column and row, or zero
// coordinates with empty_frame set when no pixel was counted.
// Throughput: one pixel per cycle within a frame; after the closing pixel
// in_ready stays low through the 10 divide steps, one quotient bit each,
// and then the load of the output register, which waits while that
// register still holds a result the receiver has not taken.
// The output register lets a new frame stream in while a result waits; once
// that frame has closed and divided, a stalled receiver keeps in_ready low
// until the waiting result transfers.
// cfg_wr_en writes the dark threshold; the user writes it only while idle, the block does not enforce this.
// Reset clears sums and output valid and sets the threshold to 100.
module threshold_centroid_unit
	import tcu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [THR_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [GRAY_W-1:0]  gray,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               empty_frame
);

	tcu_cmd_t cmd;

	tcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tcu_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.gray        (gray),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.center_x    (center_x),
		.center_y    (center_y),
		.empty_frame (empty_frame)
	);

endmodule

/* bench/centroid_checker.sv */
// watches the pixel and centroid channels, predicts each frame's centroid and compares
module centroid_checker
	import tcu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [THR_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [GRAY_W-1:0]  gray,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic               frame_end,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [COORD_W-1:0] center_x,
	input  logic [COORD_W-1:0] center_y,
	input  logic               empty_frame,
	input  logic               drain_done,
	output int                 pending,
	output int                 errors
);

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic               empty;
	} centroid_t;

	centroid_t          centroid_q[$];
	logic [THR_W-1:0]   dark_thr;
	logic [SUM_W-1:0]   acc_x;
	logic [SUM_W-1:0]   acc_y;
	logic [CNT_W-1:0]   acc_count;
	logic               leftover_checked;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SUM_W:0]   wide_x;
		logic [SUM_W:0]   wide_y;
		logic [SUM_W-1:0] sx;
		logic [SUM_W-1:0] sy;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] qx;
		logic [SUM_W-1:0] qy;
		centroid_t        want;
		if (!arst_n) begin
			dark_thr <= THR_RESET;
			acc_x <= '0;
			acc_y <= '0;
			acc_count <= '0;
			centroid_q.delete();
			pending <= 0;
			errors = 0;
			leftover_checked <= 1'b0;
		end else begin
			if (cfg_wr_en)
				dark_thr <= cfg_wr_data;
			if (in_valid && in_ready) begin
				sx = acc_x;
				sy = acc_y;
				cnt = acc_count;
				if (gray < dark_thr && pos_x < MAX_WIDTH && pos_y < MAX_HEIGHT) begin
					wide_x = {1'b0, sx} + pos_x;
					wide_y = {1'b0, sy} + pos_y;
					// a pixel that would overflow any accumulator is dropped
					if (wide_x <= SUM_LIMIT && wide_y <= SUM_LIMIT && cnt < COUNT_LIMIT) begin
						sx = wide_x[SUM_W-1:0];
						sy = wide_y[SUM_W-1:0];
						cnt = cnt + 1'b1;
					end
				end
				if (frame_end) begin
					if (cnt == '0) begin
						want.cx = '0;
						want.cy = '0;
						want.empty = 1'b1;
					end else begin
						qx = sx / cnt;
						qy = sy / cnt;
						want.cx = qx[COORD_W-1:0];
						want.cy = qy[COORD_W-1:0];
						want.empty = 1'b0;
					end
					centroid_q.push_back(want);
					sx = '0;
					sy = '0;
					cnt = '0;
				end
				acc_x <= sx;
				acc_y <= sy;
				acc_count <= cnt;
			end
			if (out_valid && out_ready) begin
				if (centroid_q.size() == 0) begin
					report_mismatch("unexpected result, pending", 0, 0);
				end else begin
					want = centroid_q.pop_front();
					if (center_x !== want.cx)
						report_mismatch("center_x", center_x, want.cx);
					if (center_y !== want.cy)
						report_mismatch("center_y", center_y, want.cy);
					if (empty_frame !== want.empty)
						report_mismatch("empty_frame", empty_frame, want.empty);
				end
			end
			if (drain_done && !leftover_checked) begin
				leftover_checked <= 1'b1;
				if (centroid_q.size() != 0)
					report_mismatch("results never delivered", 0, centroid_q.size());
			end
			pending <= centroid_q.size();
		end
	end

endmodule

/* bench/tb.sv */
// top of the threshold centroid unit bench: clock, reset, pixel stimulus and verdict
module tb;
	import tcu_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [THR_W-1:0]   cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic [GRAY_W-1:0]  gray;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic               frame_end;
	logic               out_valid;
	logic               out_ready;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;
	logic               empty_frame;
	logic               drain_done;
	logic               quiet;
	int                 pending;
	int                 errors;
	int                 pixels_sent;
	logic [THR_W-1:0]   cur_thr;

	threshold_centroid_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.gray        (gray),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.center_x    (center_x),
		.center_y    (center_y),
		.empty_frame (empty_frame)
	);

	centroid_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.gray        (gray),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.center_x    (center_x),
		.center_y    (center_y),
		.empty_frame (empty_frame),
		.drain_done  (drain_done),
		.pending     (pending),
		.errors      (errors)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("threshold_centroid_unit verification failed");
		$finish;
	end

	// receiver: ready bursts and stall bursts, always ready once quiet
	initial begin
		forever begin
			if (quiet === 1'b1 || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [GRAY_W-1:0] g, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic last, input bit gaps);
		in_valid <= 1'b1;
		gray <= g;
		pos_x <= x;
		pos_y <= y;
		frame_end <= last;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// hold off until every centroid is out and the dividers are quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		cur_thr = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_frame(input int len, input bit gaps);
		logic [GRAY_W-1:0]  g;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0, 1:    g = GRAY_W'($urandom_range(0, 255));
				2:       g = GRAY_W'(cur_thr + $urandom_range(0, 3) - 2);
				default: g = ($urandom_range(0, 1) != 0) ? '0 : '1;
			endcase
			case ($urandom_range(0, 7))
				0:       x = '0;
				1:       x = '1;
				default: x = COORD_W'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(0, 7))
				0:       y = '0;
				1:       y = '1;
				default: y = COORD_W'($urandom_range(0, 1023));
			endcase
			send_pixel(g, x, y, i == len - 1, gaps);
		end
	endtask

	initial begin
		int base;
		int len;
		logic [THR_W-1:0] phase_thr;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		gray <= '0;
		pos_x <= '0;
		pos_y <= '0;
		frame_end <= 1'b0;
		drain_done <= 1'b0;
		quiet <= 1'b0;
		pixels_sent = 0;
		cur_thr = THR_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: corner pixel, boundary gray, truncation, empty frame
		send_pixel(8'd0, 10'd1023, 10'd1023, 1'b1, 1'b1);
		send_pixel(8'd99, 10'd0, 10'd0, 1'b0, 1'b1);
		send_pixel(8'd100, 10'd500, 10'd500, 1'b0, 1'b1);
		send_pixel(8'd255, 10'd10, 10'd10, 1'b0, 1'b1);
		send_pixel(8'd0, 10'd1, 10'd2, 1'b1, 1'b1);
		send_pixel(8'd100, 10'd5, 10'd5, 1'b1, 1'b1);
		send_pixel(8'd0, 10'd1, 10'd1, 1'b0, 1'b1);
		send_pixel(8'd1, 10'd1, 10'd2, 1'b0, 1'b1);
		send_pixel(8'd50, 10'd1, 10'd2, 1'b0, 1'b1);
		send_pixel(8'd98, 10'd1022, 10'd1023, 1'b1, 1'b1);
		settle();
		// zero threshold counts nothing
		write_threshold(9'd0);
		send_pixel(8'd0, 10'd3, 10'd3, 1'b1, 1'b1);
		settle();
		// full-scale threshold counts everything
		write_threshold(9'd511);
		send_pixel(8'd255, 10'd1023, 10'd0, 1'b0, 1'b1);
		send_pixel(8'd128, 10'd0, 10'd1023, 1'b1, 1'b1);
		settle();
		write_threshold(9'd256);
		send_pixel(8'd255, 10'd7, 10'd9, 1'b1, 1'b1);
		settle();
		write_threshold(9'd1);
		send_pixel(8'd0, 10'd4, 10'd4, 1'b0, 1'b1);
		send_pixel(8'd1, 10'd8, 10'd8, 1'b1, 1'b1);
		settle();

		base = pixels_sent;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       phase_thr = 9'd0;
				1:       phase_thr = 9'd511;
				2:       phase_thr = 9'd256;
				3:       phase_thr = 9'd255;
				4:       phase_thr = 9'd1;
				default: phase_thr = THR_W'($urandom_range(2, 254));
			endcase
			write_threshold(phase_thr);
			if (p == 7)
				quiet <= 1'b1;
			while (pixels_sent < base + (p + 1) * 160) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
					: $urandom_range(1, 20);
				send_frame(len, $urandom_range(0, 3) != 0);
			end
			settle();
		end

		drain_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("threshold_centroid_unit verification clean");
		else
			$display("threshold_centroid_unit verification failed");
		$finish;
	end

endmodule
